/* rtl/uer_pkg.sv */
package uer_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_MAX    = 2'd2;

    localparam logic [15:0] PERIOD_RST = 16'd27648;
    localparam logic [7:0]  WIDTH_RST  = 8'd18;
    localparam logic [7:0]  MAX_RST    = 8'd50;

    localparam logic [9:0] DIST_STEP = 10'd17;
    localparam logic [9:0] DIST_DEN  = 10'd1000;
    localparam logic [7:0] DIST_SAT  = 8'd255;

    typedef struct packed {
        logic echo_level;
    } t_echo_in;

    typedef struct packed {
        logic       trigger_out;
        logic       measure_done;
        logic [7:0] distance_cm;
        logic       out_of_range;
        logic [3:0] digit_hundreds;
        logic [3:0] digit_tens;
        logic [3:0] digit_ones;
        logic       display_blank;
    } t_range_out;

endpackage

/* rtl/uer_stream_if.sv */
interface uer_stream_if #(
    parameter type t_word = logic
) ();
    logic  valid;
    logic  ready;
    t_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ultrasonic_echo_ranger.sv */
// Ultrasonic echo ranger.
// i_echo carries one word per timer tick holding the sampled echo pin level.
// o_range returns exactly one word per accepted tick: the trigger drive level,
// a measurement strobe, the last distance in cm (saturated at 255), the
// out-of-range / blank flag and the three display digits.
// Distance is floor(echo_ticks * 17 / 1000), tracked incrementally while the
// echo is high (quotient plus remainder modulo 1000), so no divider is needed.
// The result word is registered in the cycle its tick is taken.
// Throughput: one tick per cycle while o_range is ready; the single output
// register lets a new tick in during the same cycle the held result is taken.
// Stall: while o_range holds a word that is not taken, i_echo.ready is low
// and all ranging state holds; APB register writes still take effect.
// Reset (i_rst_n low, synchronous): counters clear, the display reads blank,
// the registers return to period 27648, width 18, limit 50 cm.
// APB: period at 0x0, width at 0x4, limit at 0x8; pready is always high and
// writes complete in the access cycle.
module ultrasonic_echo_ranger #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    uer_stream_if.sink                  i_echo,
    uer_stream_if.source                o_range,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [uer_pkg::APB_AW-1:0]  paddr,
    input  logic [uer_pkg::APB_DW-1:0]  pwdata,
    output logic [uer_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import uer_pkg::*;

    localparam int DIST_W = (COUNT_WIDTH - 5 > 1) ? COUNT_WIDTH - 5 : 1;
    localparam int CMP_W  = (DIST_W > 8) ? DIST_W : 8;

    logic [15:0] r_cfg_period;
    logic [7:0]  r_cfg_width;
    logic [7:0]  r_cfg_max;

    logic [15:0]            r_period, n_period;
    logic [7:0]             r_pulse, n_pulse;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [DIST_W-1:0]      r_dist, n_dist;
    logic [9:0]             r_rem, n_rem;
    logic                   r_ovf, n_ovf;
    logic                   r_prev, n_prev;
    logic [7:0]             r_shown, n_shown;
    logic                   r_blank, n_blank;

    logic       r_out_valid;
    t_range_out r_out, n_out;

    logic        accept;
    logic        cfg_wr;
    logic        level;
    logic        trig;
    logic        done;
    logic [15:0] period_inc;
    logic [9:0]  rem_sum;
    logic [CMP_W-1:0] dist_ext;
    logic [6:0]  rem_h;
    logic [14:0] tens_prod;
    logic [3:0]  d_hund, d_tens, d_ones;

    assign pready       = 1'b1;
    assign cfg_wr       = psel & penable & pwrite;
    assign i_echo.ready = !r_out_valid || o_range.ready;
    assign accept       = i_echo.valid && i_echo.ready;
    assign level        = i_echo.data.echo_level;

    always_comb begin
        unique case (paddr[3:2])
            REG_PERIOD: prdata = {16'b0, r_cfg_period};
            REG_WIDTH:  prdata = {24'b0, r_cfg_width};
            REG_MAX:    prdata = {24'b0, r_cfg_max};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_period <= PERIOD_RST;
            r_cfg_width  <= WIDTH_RST;
            r_cfg_max    <= MAX_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_PERIOD: r_cfg_period <= pwdata[15:0];
                REG_WIDTH:  r_cfg_width  <= pwdata[7:0];
                REG_MAX:    r_cfg_max    <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        trig    = r_pulse != 8'd0;
        n_pulse = trig ? r_pulse - 8'd1 : r_pulse;
        period_inc = r_period + 16'd1;
        if (period_inc >= r_cfg_period) begin
            n_period = '0;
            n_pulse  = r_cfg_width;
        end else begin
            n_period = period_inc;
        end

        n_count  = r_count;
        n_dist   = r_dist;
        n_rem    = r_rem;
        n_ovf    = r_ovf;
        n_shown  = r_shown;
        n_blank  = r_blank;
        done     = 1'b0;
        rem_sum  = r_rem + DIST_STEP;
        dist_ext = CMP_W'(r_dist);

        if (level) begin
            if (!r_prev) begin
                n_count = COUNT_WIDTH'(1);
                n_rem   = DIST_STEP;
                n_dist  = '0;
            end else begin
                n_count = r_count + COUNT_WIDTH'(1);
                if (n_count == '0) begin
                    n_ovf  = 1'b1;
                    n_rem  = '0;
                    n_dist = '0;
                end else if (rem_sum >= DIST_DEN) begin
                    n_rem  = rem_sum - DIST_DEN;
                    n_dist = r_dist + DIST_W'(1);
                end else begin
                    n_rem  = rem_sum;
                end
            end
        end else if (r_prev) begin
            done    = 1'b1;
            n_blank = (dist_ext > CMP_W'(r_cfg_max)) || r_ovf;
            n_shown = (dist_ext > CMP_W'(DIST_SAT)) ? DIST_SAT : dist_ext[7:0];
            n_ovf   = 1'b0;
        end
        n_prev = level;
    end

    always_comb begin
        priority if (n_shown >= 8'd200) begin
            d_hund = 4'd2;
            rem_h  = 7'(n_shown - 8'd200);
        end else if (n_shown >= 8'd100) begin
            d_hund = 4'd1;
            rem_h  = 7'(n_shown - 8'd100);
        end else begin
            d_hund = 4'd0;
            rem_h  = n_shown[6:0];
        end
        tens_prod = 15'(rem_h) * 15'd205;
        d_tens    = tens_prod[14:11];
        d_ones    = 4'(rem_h - 7'(d_tens) * 7'd10);

        n_out.trigger_out    = trig;
        n_out.measure_done   = done;
        n_out.distance_cm    = n_shown;
        n_out.out_of_range   = n_blank;
        n_out.display_blank  = n_blank;
        n_out.digit_hundreds = n_blank ? 4'd0 : d_hund;
        n_out.digit_tens     = n_blank ? 4'd0 : d_tens;
        n_out.digit_ones     = n_blank ? 4'd0 : d_ones;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= '0;
            r_pulse     <= '0;
            r_count     <= '0;
            r_dist      <= '0;
            r_rem       <= '0;
            r_ovf       <= 1'b0;
            r_prev      <= 1'b0;
            r_shown     <= '0;
            r_blank     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_period    <= n_period;
                r_pulse     <= n_pulse;
                r_count     <= n_count;
                r_dist      <= n_dist;
                r_rem       <= n_rem;
                r_ovf       <= n_ovf;
                r_prev      <= n_prev;
                r_shown     <= n_shown;
                r_blank     <= n_blank;
                r_out_valid <= 1'b1;
            end else if (o_range.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_range.valid = r_out_valid;
    assign o_range.data  = r_out;

endmodule

/* rtl/uer_checker.sv */
module uer_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input uer_pkg::t_range_out i_out_data
);
    import uer_pkg::*;

    logic [9:0] digit_sum;

    assign digit_sum = 10'(i_out_data.digit_hundreds) * 10'd100
                     + 10'(i_out_data.digit_tens) * 10'd10
                     + 10'(i_out_data.digit_ones);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word present right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result word changed");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("tick taken while result word is stalled");

    a_blank_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.out_of_range == i_out_data.display_blank)
        else $error("range flag and blank flag disagree");

    a_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.display_blank
            |-> digit_sum == 10'(i_out_data.distance_cm))
        else $error("digits do not match distance");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_echo.ready),
    .i_out_valid (o_range.valid),
    .i_out_ready (o_range.ready),
    .i_out_data  (o_range.data)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import uer_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_e;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    uer_stream_if #(.t_word(t_echo_in))   echo_if ();
    uer_stream_if #(.t_word(t_range_out)) range_if ();

    ultrasonic_echo_ranger DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_echo  (echo_if),
        .o_range (range_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [15:0] cfg_period = PERIOD_RST;
    logic [7:0]  cfg_width  = WIDTH_RST;
    logic [7:0]  cfg_limit  = MAX_RST;

    logic [15:0]              period_ticks = '0;
    logic [7:0]               pulse_left   = '0;
    logic [COUNT_WIDTH_DEF-1:0] echo_ticks = '0;
    logic                     echo_wrapped = 1'b0;
    logic                     echo_was_high = 1'b0;
    logic [7:0]               shown_cm     = '0;
    logic                     shown_blank  = 1'b1;

    t_range_out  pending_ranges[$];
    t_range_out  want;
    int          mismatches = 0;

    int unsigned burst_left = 0;
    int unsigned max_gap    = 0;
    logic [15:0] stall_pattern = '0;
    logic [3:0]  stall_pos     = '0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic t_range_out ranger_tick(input logic level);
        t_range_out  r;
        int unsigned dist_cm;
        r = '0;
        if (pulse_left != 0) begin
            r.trigger_out = 1'b1;
            pulse_left = pulse_left - 8'd1;
        end
        period_ticks = period_ticks + 16'd1;
        if (period_ticks >= cfg_period) begin
            period_ticks = '0;
            pulse_left = cfg_width;
        end
        if (level) begin
            if (!echo_was_high)
                echo_ticks = '0;
            echo_ticks = echo_ticks + 1'b1;
            if (echo_ticks == 0)
                echo_wrapped = 1'b1;
        end else if (echo_was_high) begin
            dist_cm = (32'(echo_ticks) * 32'd17) / 32'd1000;
            shown_blank = (dist_cm > 32'(cfg_limit)) || echo_wrapped;
            shown_cm = (dist_cm > 32'd255) ? 8'd255 : dist_cm[7:0];
            echo_wrapped = 1'b0;
            r.measure_done = 1'b1;
        end
        echo_was_high = level;
        r.distance_cm   = shown_cm;
        r.out_of_range  = shown_blank;
        r.display_blank = shown_blank;
        if (!shown_blank) begin
            r.digit_hundreds = 4'(shown_cm / 8'd100);
            r.digit_tens     = 4'((shown_cm / 8'd10) % 8'd10);
            r.digit_ones     = 4'(shown_cm % 8'd10);
        end
        return r;
    endfunction

    task automatic check_field(input string field, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        range_if.ready <= !stall_pattern[stall_pos];
        stall_pos <= stall_pos + 4'd1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && range_if.valid && range_if.ready) begin
            if (pending_ranges.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %h", $time,
                         range_if.data);
                mismatches++;
            end else begin
                want = pending_ranges.pop_front();
                check_field("trigger_out", want.trigger_out, range_if.data.trigger_out);
                check_field("measure_done", want.measure_done,
                            range_if.data.measure_done);
                check_field("distance_cm", want.distance_cm, range_if.data.distance_cm);
                check_field("out_of_range", want.out_of_range,
                            range_if.data.out_of_range);
                check_field("digit_hundreds", want.digit_hundreds,
                            range_if.data.digit_hundreds);
                check_field("digit_tens", want.digit_tens, range_if.data.digit_tens);
                check_field("digit_ones", want.digit_ones, range_if.data.digit_ones);
                check_field("display_blank", want.display_blank,
                            range_if.data.display_blank);
            end
        end
    end

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_NONE: begin
                max_gap = 0;
                stall_pattern = '0;
            end
            IDLE_LIGHT: begin
                max_gap = 3;
                stall_pattern = 16'($urandom() & $urandom());
            end
            default: begin
                max_gap = 12;
                stall_pattern = 16'($urandom()) & 16'hFFFE;
            end
        endcase
    endtask

    task automatic send_tick(input logic level);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap != 0) begin
                echo_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        echo_if.valid <= 1'b1;
        echo_if.data  <= t_echo_in'(level);
        do @(posedge i_clk); while (!echo_if.ready);
        pending_ranges.push_back(ranger_tick(level));
    endtask

    task automatic echo_pulse(input int unsigned high_ticks, input int unsigned low_ticks);
        repeat (high_ticks) send_tick(1'b1);
        repeat (low_ticks) send_tick(1'b0);
    endtask

    task automatic settle();
        echo_if.valid <= 1'b0;
        while (pending_ranges.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic is_write, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] stored;
        settle();
        apb_access(1'b1, idx, value, readback);
        case (idx)
            REG_PERIOD: begin
                cfg_period = value[15:0];
                stored = {16'h0, value[15:0]};
            end
            REG_WIDTH: begin
                cfg_width = value[7:0];
                stored = {24'h0, value[7:0]};
            end
            default: begin
                cfg_limit = value[7:0];
                stored = {24'h0, value[7:0]};
            end
        endcase
        apb_access(1'b0, idx, '0, readback);
        if (readback !== stored) begin
            $display("%0t: register %0d expected %h actual %h", $time, idx, stored,
                     readback);
            mismatches++;
        end
    endtask

    task automatic test_power_on();
        set_idling(IDLE_LIGHT);
        repeat (10) send_tick(1'b0);
        echo_pulse(1, 5);
        echo_pulse(59, 5);
    endtask

    task automatic test_trigger_timing();
        set_idling(IDLE_HEAVY);
        write_reg(REG_PERIOD, 32'd5);
        write_reg(REG_WIDTH, 32'd2);
        repeat (20) send_tick(1'b0);
        write_reg(REG_PERIOD, 32'd1);
        write_reg(REG_WIDTH, 32'd1);
        repeat (12) send_tick(1'b0);
        write_reg(REG_PERIOD, 32'd0);
        write_reg(REG_WIDTH, 32'd3);
        repeat (12) send_tick(1'b0);
        write_reg(REG_PERIOD, 32'd3);
        write_reg(REG_WIDTH, 32'd0);
        repeat (12) send_tick(1'b0);
        write_reg(REG_PERIOD, 32'd6);
        write_reg(REG_WIDTH, 32'd255);
        echo_pulse(40, 6);
    endtask

    task automatic test_digits_and_limit();
        set_idling(IDLE_LIGHT);
        write_reg(REG_PERIOD, 32'd40);
        write_reg(REG_WIDTH, 32'd4);
        write_reg(REG_MAX, 32'd255);
        echo_pulse(70, 3);
        write_reg(REG_MAX, 32'd1);
        echo_pulse(117, 3);
        echo_pulse(118, 3);
        write_reg(REG_MAX, 32'd0);
        set_idling(IDLE_HEAVY);
        echo_pulse(58, 3);
        echo_pulse(59, 3);
    endtask

    task automatic test_random_ranging();
        int unsigned len;
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(REG_PERIOD, ($urandom_range(0, 9) == 0) ? 32'd65535 :
                                  $urandom_range(0, 64));
            write_reg(REG_WIDTH, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
                                 $urandom_range(0, 8));
            write_reg(REG_MAX, (ph % 4 == 0) ? $urandom_range(0, 255) :
                               $urandom_range(0, 6));
            set_idling(idle_mode_e'($urandom_range(0, 2)));
            for (int p = 0; p < 3; p++) begin
                case ($urandom_range(0, 9))
                    0:       len = $urandom_range(100, 200);
                    1: begin
                        len = 0;
                        repeat (20) send_tick(1'($urandom_range(0, 1)));
                    end
                    default: len = $urandom_range(1, 30);
                endcase
                if (len != 0)
                    echo_pulse(len, $urandom_range(1, 8));
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        echo_if.valid  = 1'b0;
        echo_if.data   = '0;
        range_if.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on();
        test_trigger_timing();
        test_digits_and_limit();
        test_random_ranging();

        settle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
